FILE: rtl/dts_pkg.sv
package dts_pkg;

    // Vertex numbers are six bits wide on both channels, so the vertex space is fixed.
    localparam int VTX_W        = 6;
    localparam int MAX_VERTICES = 64;
    localparam int CNT_W        = 7;

    localparam logic [1:0] CMD_ADD   = 2'd0;
    localparam logic [1:0] CMD_SORT  = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;
    localparam logic [1:0] CMD_NOP   = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    localparam logic KIND_ACK   = 1'b0;
    localparam logic KIND_ORDER = 1'b1;

    typedef struct packed {
        logic [1:0]       command;
        logic [VTX_W-1:0] edge_source;
        logic [VTX_W-1:0] edge_target;
    } t_in_item;

    typedef struct packed {
        logic             result_kind;
        logic [VTX_W-1:0] sorted_vertex;
        logic             last_entry;
        logic [1:0]       status;
    } t_out_item;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ADD_REQ,
        S_ADD_WR,
        S_ADD_LINK,
        S_ACK,
        S_ROOT,
        S_ENTER,
        S_STEP,
        S_POP,
        S_EDGE,
        S_EMIT_RD,
        S_EMIT_OUT
    } t_state;

endpackage

FILE: rtl/dts_ram.sv
module dts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/dfs_topological_sort_core.sv
// Topological sort engine working by depth-first search.
// Items enter on the input channel (i_in_valid, o_in_ready, i_in_item) and each
// command yields its results on the output channel (o_out_valid, i_out_ready,
// o_out_item). An add-edge item appends the edge to its source vertex's list and
// is answered by one acknowledgment whose status tells whether the edge was kept,
// dropped for a vertex out of range, or dropped because the edge store is full.
// A clear item empties the graph and is acknowledged. A sort item runs the search
// from vertex 0 upward and then emits the vertices in reverse finishing order,
// with last_entry set on the final one; an empty graph gives no result.
// The block takes one item at a time. A stored add passes the request and write
// states, and the link state when the source list already has edges, before its
// acknowledgment; a dropped add and a clear go straight to the acknowledgment,
// each waiting there for the output register. A sort checks roots, enters
// vertices, walks edges and finishes vertices, then reads out and emits each
// finished vertex, paced by the single read port of the list, edge and stack memories.
// A result sits in an output register, so a stalled receiver holds the sequencer
// only when it has another result to hand over.
// Reset sets vertex_count to 64 and empties the graph at once through per-vertex
// list valid bits; no clearing pass is needed. The user must write vertex_count
// through the APB port at address 0 only while the block is idle; it is not checked.
module dfs_topological_sort_core #(
    parameter int MAX_EDGES = 256
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  dts_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output dts_pkg::t_out_item o_out_item,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import dts_pkg::*;

    // Edge indexes, plus one code past the last edge that marks the end of a list.
    localparam int EIW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int EW  = $clog2(MAX_EDGES + 1);
    localparam logic [EW-1:0] EdgeNull = EW'(MAX_EDGES);
    localparam int WALK_W = VTX_W + EW;

    t_state r_state, n_state;

    logic [CNT_W-1:0]        r_vc, n_vc;
    logic [VTX_W-1:0]        r_src, n_src, r_tgt, n_tgt;
    logic [1:0]              r_status, n_status;
    logic [MAX_VERTICES-1:0] r_list_valid, n_list_valid;
    logic [MAX_VERTICES-1:0] r_visited, n_visited;
    logic [EW-1:0]           r_edges, n_edges;
    logic [EIW-1:0]          r_old_tail, n_old_tail;
    logic [CNT_W-1:0]        r_root, n_root, r_depth, n_depth, r_done, n_done;
    logic [VTX_W-1:0]        r_top_v, n_top_v, r_enter_v, n_enter_v;
    logic [EW-1:0]           r_top_e, n_top_e;
    logic                    r_out_valid, n_out_valid;
    t_out_item               r_out, n_out;

    logic [CNT_W-1:0] cnt_eff;
    logic             out_free;
    logic [CNT_W-1:0] depth_m1, depth_m2, done_m1;

    // Memory ports.
    logic                 list_we;
    logic [VTX_W-1:0]     list_waddr, list_raddr;
    logic [2*EIW-1:0]     list_wdata, list_rdata;
    logic                 dest_we;
    logic [EIW-1:0]       dest_waddr, edge_raddr;
    logic [VTX_W-1:0]     dest_wdata, dest_rdata;
    logic                 next_we;
    logic [EIW-1:0]       next_waddr;
    logic [EW-1:0]        next_wdata, next_rdata;
    logic                 walk_we;
    logic [VTX_W-1:0]     walk_waddr, walk_raddr;
    logic [WALK_W-1:0]    walk_wdata, walk_rdata;
    logic                 fin_we;
    logic [VTX_W-1:0]     fin_waddr, fin_raddr;
    logic [VTX_W-1:0]     fin_wdata, fin_rdata;

    // Each list entry holds the head edge in its upper half and the tail edge below.
    dts_ram #(.WIDTH(2 * EIW), .DEPTH(MAX_VERTICES)) u_list_ram (
        .i_clk(i_clk), .i_we(list_we), .i_waddr(list_waddr), .i_wdata(list_wdata),
        .i_raddr(list_raddr), .o_rdata(list_rdata)
    );
    dts_ram #(.WIDTH(VTX_W), .DEPTH(MAX_EDGES)) u_dest_ram (
        .i_clk(i_clk), .i_we(dest_we), .i_waddr(dest_waddr), .i_wdata(dest_wdata),
        .i_raddr(edge_raddr), .o_rdata(dest_rdata)
    );
    dts_ram #(.WIDTH(EW), .DEPTH(MAX_EDGES)) u_next_ram (
        .i_clk(i_clk), .i_we(next_we), .i_waddr(next_waddr), .i_wdata(next_wdata),
        .i_raddr(edge_raddr), .o_rdata(next_rdata)
    );
    // The top of the walk stack lives in registers; the memory holds the entries below.
    dts_ram #(.WIDTH(WALK_W), .DEPTH(MAX_VERTICES)) u_walk_ram (
        .i_clk(i_clk), .i_we(walk_we), .i_waddr(walk_waddr), .i_wdata(walk_wdata),
        .i_raddr(walk_raddr), .o_rdata(walk_rdata)
    );
    dts_ram #(.WIDTH(VTX_W), .DEPTH(MAX_VERTICES)) u_fin_ram (
        .i_clk(i_clk), .i_we(fin_we), .i_waddr(fin_waddr), .i_wdata(fin_wdata),
        .i_raddr(fin_raddr), .o_rdata(fin_rdata)
    );

    // A count above the vertex space saturates; zero means an empty graph.
    assign cnt_eff  = (r_vc > CNT_W'(MAX_VERTICES)) ? CNT_W'(MAX_VERTICES) : r_vc;
    assign out_free = !r_out_valid || i_out_ready;
    assign depth_m1 = r_depth - CNT_W'(1);
    assign depth_m2 = r_depth - CNT_W'(2);
    assign done_m1  = r_done - CNT_W'(1);

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;
    assign pready      = 1'b1;
    assign prdata      = paddr[2] ? 32'd0 : {{(32 - CNT_W){1'b0}}, r_vc};

    always_comb begin
        n_state      = r_state;
        n_vc         = r_vc;
        n_src        = r_src;
        n_tgt        = r_tgt;
        n_status     = r_status;
        n_list_valid = r_list_valid;
        n_visited    = r_visited;
        n_edges      = r_edges;
        n_old_tail   = r_old_tail;
        n_root       = r_root;
        n_depth      = r_depth;
        n_done       = r_done;
        n_top_v      = r_top_v;
        n_top_e      = r_top_e;
        n_enter_v    = r_enter_v;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_out        = r_out;

        list_we    = 1'b0;
        list_waddr = r_src;
        list_wdata = {r_edges[EIW-1:0], r_edges[EIW-1:0]};
        list_raddr = r_src;
        dest_we    = 1'b0;
        dest_waddr = r_edges[EIW-1:0];
        dest_wdata = r_tgt;
        edge_raddr = r_top_e[EIW-1:0];
        next_we    = 1'b0;
        next_waddr = r_edges[EIW-1:0];
        next_wdata = EdgeNull;
        walk_we    = 1'b0;
        walk_waddr = depth_m1[VTX_W-1:0];
        walk_wdata = {r_top_v, r_top_e};
        walk_raddr = depth_m2[VTX_W-1:0];
        fin_we     = 1'b0;
        fin_waddr  = r_done[VTX_W-1:0];
        fin_wdata  = r_top_v;
        fin_raddr  = r_done[VTX_W-1:0];

        if (psel && penable && pwrite && !paddr[2]) begin
            n_vc = pwdata[CNT_W-1:0];
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_src = i_in_item.edge_source;
                    n_tgt = i_in_item.edge_target;
                    case (i_in_item.command)
                        CMD_ADD: begin
                            if ({1'b0, i_in_item.edge_source} >= cnt_eff ||
                                {1'b0, i_in_item.edge_target} >= cnt_eff) begin
                                n_status = ST_RANGE;
                                n_state  = S_ACK;
                            end else if (r_edges == EdgeNull) begin
                                n_status = ST_FULL;
                                n_state  = S_ACK;
                            end else begin
                                n_state = S_ADD_REQ;
                            end
                        end
                        CMD_SORT: begin
                            n_visited = '0;
                            n_root    = '0;
                            n_depth   = '0;
                            n_done    = '0;
                            n_state   = S_ROOT;
                        end
                        CMD_CLEAR: begin
                            n_list_valid = '0;
                            n_edges      = '0;
                            n_status     = ST_OK;
                            n_state      = S_ACK;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_ADD_REQ: begin
                n_state = S_ADD_WR;
            end
            S_ADD_WR: begin
                dest_we = 1'b1;
                next_we = 1'b1;
                list_we = 1'b1;
                if (r_list_valid[r_src]) begin
                    list_wdata = {list_rdata[2*EIW-1:EIW], r_edges[EIW-1:0]};
                    n_state    = S_ADD_LINK;
                end else begin
                    n_state = S_ACK;
                end
                n_old_tail          = list_rdata[EIW-1:0];
                n_list_valid[r_src] = 1'b1;
                n_edges             = r_edges + EW'(1);
                n_status            = ST_OK;
            end
            S_ADD_LINK: begin
                // The edge just stored is one below the updated count.
                next_we    = 1'b1;
                next_waddr = r_old_tail;
                next_wdata = r_edges - EW'(1);
                n_state    = S_ACK;
            end
            S_ACK: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out       = '{result_kind: KIND_ACK, sorted_vertex: '0,
                                    last_entry: 1'b1, status: r_status};
                    n_state     = S_IDLE;
                end
            end
            S_ROOT: begin
                list_raddr = r_root[VTX_W-1:0];
                if (r_root == cnt_eff) begin
                    n_state = S_EMIT_RD;
                end else if (r_visited[r_root[VTX_W-1:0]]) begin
                    n_root = r_root + CNT_W'(1);
                end else begin
                    n_visited[r_root[VTX_W-1:0]] = 1'b1;
                    n_enter_v = r_root[VTX_W-1:0];
                    n_state   = S_ENTER;
                end
            end
            S_ENTER: begin
                if (r_depth != '0) begin
                    walk_we = 1'b1;
                end
                n_top_v = r_enter_v;
                n_top_e = r_list_valid[r_enter_v] ?
                          EW'(list_rdata[2*EIW-1:EIW]) : EdgeNull;
                n_depth = r_depth + CNT_W'(1);
                n_state = S_STEP;
            end
            S_STEP: begin
                if (r_top_e == EdgeNull) begin
                    fin_we  = 1'b1;
                    n_done  = r_done + CNT_W'(1);
                    n_depth = depth_m1;
                    if (r_depth == CNT_W'(1)) begin
                        n_root  = r_root + CNT_W'(1);
                        n_state = S_ROOT;
                    end else begin
                        n_state = S_POP;
                    end
                end else begin
                    n_state = S_EDGE;
                end
            end
            S_POP: begin
                walk_raddr = r_depth[VTX_W-1:0] - VTX_W'(1);
                n_top_v    = walk_rdata[WALK_W-1:EW];
                n_top_e    = walk_rdata[EW-1:0];
                n_state    = S_STEP;
            end
            S_EDGE: begin
                list_raddr = dest_rdata;
                n_top_e    = next_rdata;
                if ({1'b0, dest_rdata} < cnt_eff && !r_visited[dest_rdata] &&
                    r_depth < CNT_W'(MAX_VERTICES)) begin
                    n_visited[dest_rdata] = 1'b1;
                    n_enter_v = dest_rdata;
                    n_state   = S_ENTER;
                end else begin
                    n_state = S_STEP;
                end
            end
            S_EMIT_RD: begin
                fin_raddr = done_m1[VTX_W-1:0];
                if (r_done == '0) begin
                    n_state = S_IDLE;
                end else begin
                    n_done  = done_m1;
                    n_state = S_EMIT_OUT;
                end
            end
            S_EMIT_OUT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out       = '{result_kind: KIND_ORDER, sorted_vertex: fin_rdata,
                                    last_entry: (r_done == '0), status: ST_OK};
                    n_state     = (r_done == '0) ? S_IDLE : S_EMIT_RD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_vc         <= CNT_W'(MAX_VERTICES);
            r_list_valid <= '0;
            r_edges      <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_vc         <= n_vc;
            r_list_valid <= n_list_valid;
            r_edges      <= n_edges;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_src      <= n_src;
        r_tgt      <= n_tgt;
        r_status   <= n_status;
        r_visited  <= n_visited;
        r_old_tail <= n_old_tail;
        r_root     <= n_root;
        r_depth    <= n_depth;
        r_done     <= n_done;
        r_top_v    <= n_top_v;
        r_top_e    <= n_top_e;
        r_enter_v  <= n_enter_v;
        r_out      <= n_out;
    end

endmodule

FILE: rtl/dts_checker.sv
module dts_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_ready,
    input dts_pkg::t_in_item  i_in_item,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input dts_pkg::t_out_item o_out_item
);
    import dts_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("output item dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_out_item))
        else $error("output item changed while stalled");

    a_ack_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.result_kind == KIND_ACK |->
        o_out_item.last_entry && o_out_item.sorted_vertex == '0)
        else $error("acknowledgment is not a single final item");

    a_order_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.result_kind == KIND_ORDER |->
        o_out_item.status == ST_OK)
        else $error("sorted entry carries an error status");

    a_busy_after_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && i_in_item.command != CMD_NOP |=> !o_in_ready)
        else $error("engine took a command without going busy");

endmodule

bind dfs_topological_sort_core dts_checker u_dts_checker (.*);

FILE: bench/dfs_topological_sort_core_tb.sv
`timescale 1ns / 1ps

// Scoreboard for the sort engine: it keeps its own copy of the graph and, for
// every accepted item, queues the results the block must produce.
class dts_order_board;
    localparam int NV = 64;
    localparam int NE = 256;
    localparam int ENULL = 256;

    int unsigned vcount;
    int unsigned head[NV];
    int unsigned tail[NV];
    int unsigned link[NE];
    int unsigned dest[NE];
    int unsigned stored;
    dts_pkg::t_out_item pending[$];
    int errors;

    function void reset_graph();
        for (int v = 0; v < NV; v++) begin
            head[v] = ENULL;
            tail[v] = ENULL;
        end
        stored = 0;
    endfunction

    function void power_on();
        vcount = 64;
        errors = 0;
        reset_graph();
    endfunction

    // Appends one expected result at the end of the queue.
    function void add_expected(dts_pkg::t_out_item r);
        pending.insert(pending.size(), r);
    endfunction

    function void push_ack(logic [1:0] st);
        dts_pkg::t_out_item r;
        r.result_kind = dts_pkg::KIND_ACK;
        r.sorted_vertex = '0;
        r.last_entry = 1'b1;
        r.status = st;
        add_expected(r);
    endfunction

    // Works out the results of one accepted item.
    function void note_item(dts_pkg::t_in_item it);
        int unsigned n, s, t, e, depth, done, top, w;
        bit seen[NV];
        int unsigned wv[NV];
        int unsigned we[NV];
        int unsigned fin[NV];
        dts_pkg::t_out_item r;
        n = vcount > NV ? NV : vcount;
        if (it.command == dts_pkg::CMD_ADD) begin
            s = it.edge_source;
            t = it.edge_target;
            if (s >= n || t >= n) begin
                push_ack(dts_pkg::ST_RANGE);
            end else if (stored >= NE) begin
                push_ack(dts_pkg::ST_FULL);
            end else begin
                e = stored;
                stored++;
                dest[e] = t;
                link[e] = ENULL;
                if (tail[s] == ENULL) head[s] = e;
                else link[tail[s]] = e;
                tail[s] = e;
                push_ack(dts_pkg::ST_OK);
            end
        end else if (it.command == dts_pkg::CMD_CLEAR) begin
            reset_graph();
            push_ack(dts_pkg::ST_OK);
        end else if (it.command == dts_pkg::CMD_SORT) begin
            done = 0;
            for (int v = 0; v < NV; v++) seen[v] = 0;
            for (int unsigned root = 0; root < n; root++) begin
                if (!seen[root]) begin
                    seen[root] = 1;
                    wv[0] = root;
                    we[0] = head[root];
                    depth = 1;
                    while (depth > 0) begin
                        top = depth - 1;
                        e = we[top];
                        if (e >= ENULL) begin
                            fin[done] = wv[top];
                            done++;
                            depth--;
                        end else begin
                            w = dest[e];
                            we[top] = link[e];
                            if (w < n && !seen[w] && depth < NV) begin
                                seen[w] = 1;
                                wv[depth] = w;
                                we[depth] = head[w];
                                depth++;
                            end
                        end
                    end
                end
            end
            while (done > 0) begin
                done--;
                r.result_kind = dts_pkg::KIND_ORDER;
                r.sorted_vertex = fin[done][5:0];
                r.last_entry = (done == 0);
                r.status = dts_pkg::ST_OK;
                add_expected(r);
            end
        end
    endfunction

    function void check_result(dts_pkg::t_out_item got);
        dts_pkg::t_out_item x;
        if (pending.size() == 0) begin
            $error("unexpected result %h", got);
            errors++;
            return;
        end
        x = pending.pop_front();
        if (got.result_kind !== x.result_kind) begin
            $error("result_kind expected %0d actual %0d", x.result_kind, got.result_kind);
            errors++;
        end
        if (got.sorted_vertex !== x.sorted_vertex) begin
            $error("sorted_vertex expected %0d actual %0d", x.sorted_vertex,
                   got.sorted_vertex);
            errors++;
        end
        if (got.last_entry !== x.last_entry) begin
            $error("last_entry expected %0d actual %0d", x.last_entry, got.last_entry);
            errors++;
        end
        if (got.status !== x.status) begin
            $error("status expected %0d actual %0d", x.status, got.status);
            errors++;
        end
    endfunction
endclass

module dfs_topological_sort_core_tb;
    import dts_pkg::*;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    t_in_item    i_in_item = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    t_out_item   o_out_item;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    dts_order_board board;

    // When set, the receiver stalls for a long counted stretch.
    bit hold_receiver = 0;
    // Random stalls are switched off for some stretches.
    bit steady_receiver = 0;

    dfs_topological_sort_core DUT (.*);

    always #5 i_clk = ~i_clk;

    // Outputs are sampled at the rising edge; every accepted item goes to the board.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) board.note_item(i_in_item);
            if (o_out_valid && i_out_ready) board.check_result(o_out_item);
        end
    end

    // Receiver: a stall pattern of its own, plus the long hold when asked.
    initial begin
        int hold_cycles;
        forever begin
            @(negedge i_clk);
            if (hold_receiver) begin
                i_out_ready <= 1'b0;
                for (hold_cycles = 0; hold_cycles < 300; hold_cycles++) @(negedge i_clk);
                hold_receiver = 0;
            end
            if (steady_receiver) i_out_ready <= 1'b1;
            else i_out_ready <= ($urandom_range(0, 3) != 0);
        end
    end

    // Offers one item and holds it until the block accepts it.
    task automatic send_item(logic [1:0] cmd, logic [5:0] src, logic [5:0] dst);
        i_in_item <= '{command: cmd, edge_source: src, edge_target: dst};
        i_in_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic pause_sender();
        i_in_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge i_clk);
    endtask

    // Waits until every expected result has come, plus some settling time
    // for commands that produce nothing.
    task automatic drain();
        i_in_valid <= 1'b0;
        @(negedge i_clk);
        while (board.pending.size() != 0) @(negedge i_clk);
        repeat (40) @(negedge i_clk);
    endtask

    task automatic write_count(logic [31:0] value);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= '0;
        pwdata <= value;
        penable <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        board.vcount = value[6:0];
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // A random add: mostly in-range vertices, now and then any six-bit value.
    task automatic random_add(int unsigned n);
        logic [5:0] s, t;
        if (n > 0 && $urandom_range(0, 9) != 0) begin
            s = 6'($urandom_range(0, n - 1));
            t = 6'($urandom_range(0, n - 1));
        end else begin
            s = 6'($urandom);
            t = 6'($urandom);
        end
        send_item(CMD_ADD, s, t);
    endtask

    initial begin
        int unsigned counts[6] = '{64, 1, 8, 127, 0, 20};
        int unsigned n;
        int burst;
        board = new();
        board.power_on();
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed part at the reset count of 64: extremes, a chain, a cycle,
        // a self loop and an ignored command.
        send_item(CMD_SORT, 0, 0);
        send_item(CMD_ADD, 0, 63);
        send_item(CMD_ADD, 63, 0);
        send_item(CMD_ADD, 5, 5);
        send_item(CMD_ADD, 1, 2);
        send_item(CMD_ADD, 1, 3);
        send_item(CMD_ADD, 2, 3);
        send_item(CMD_NOP, 6'h3f, 6'h3f);
        send_item(CMD_SORT, 0, 0);
        drain();
        // Lowering the count leaves edges to vertices beyond it to be skipped.
        write_count(4);
        send_item(CMD_ADD, 3, 4);
        send_item(CMD_ADD, 4, 0);
        send_item(CMD_SORT, 0, 0);
        send_item(CMD_CLEAR, 0, 0);
        send_item(CMD_SORT, 0, 0);
        drain();
        // No vertices at all: every add is out of range and a sort gives nothing.
        write_count(0);
        send_item(CMD_ADD, 0, 0);
        send_item(CMD_SORT, 0, 0);
        drain();

        // Random phases over several counts, the extremes among them.
        for (int ph = 0; ph < 6; ph++) begin
            write_count(counts[ph]);
            n = counts[ph] > 64 ? 64 : counts[ph];
            if (ph == 2) hold_receiver = 1;
            steady_receiver = (ph == 4);
            for (int it = 0; it < 32; it++) begin
                burst = $urandom_range(0, 9);
                if (burst == 0) send_item(CMD_SORT, 6'($urandom), 6'($urandom));
                else if (burst == 1 && $urandom_range(0, 3) == 0)
                    send_item(CMD_CLEAR, 6'($urandom), 6'($urandom));
                else if (burst == 2 && $urandom_range(0, 5) == 0)
                    send_item(CMD_NOP, 6'($urandom), 6'($urandom));
                else random_add(n);
                if ($urandom_range(0, 4) == 0) pause_sender();
            end
            send_item(CMD_SORT, 0, 0);
            if (ph == 3) send_item(CMD_CLEAR, 0, 0);
            drain();
        end
        steady_receiver = 0;

        if (board.errors == 0 && board.pending.size() == 0) begin
            $display("dfs_topological_sort_core regression: pass");
        end else begin
            $display("dfs_topological_sort_core regression: fail");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("dfs_topological_sort_core regression: fail");
        $finish;
    end
endmodule

FILE: sim.f
rtl/dts_pkg.sv
rtl/dts_ram.sv
rtl/dfs_topological_sort_core.sv
rtl/dts_checker.sv
bench/dfs_topological_sort_core_tb.sv
